FILE: rtl/gia_pkg.sv
// gia_pkg: shared widths, register indexes, mode codes and stage structs
// for the gather index address generator. No dependencies.
package gia_pkg;

  localparam int IDX_IN_W       = 32;
  localparam int ROW_W          = 16;
  localparam int CNT_W          = 17;
  localparam int MODE_W         = 2;
  localparam int CHUNK_W        = 7;
  localparam int OFF_W          = 38;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_W          = 17;
  localparam int DIGIT_W        = 4;
  localparam int PROD_W         = ROW_W + CNT_W;
  localparam int SUM_W          = PROD_W + 1;
  localparam int MAX_CHUNK_DEF  = 64;
  localparam int INDEX_BITS_DEF = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK = 2'd2;

  localparam logic [MODE_W-1:0] MODE_RAISE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRAP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLIP  = 2'd2;

  // carried alongside the remainder pipeline
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             rend;
    logic             bad;
    logic             wrap;
    logic             neg;
    logic [CNT_W-1:0] idx;
  } gia_side_t;

  // address pipeline to emitter
  typedef struct packed {
    logic             valid;
    logic             bad;
    logic             rend;
    logic [OFF_W-1:0] offset;
  } gia_tail_t;

  // one radix-16 restoring step group: shifts DIGIT_W bits into the remainder
  function automatic logic [CNT_W-1:0] rem_step(input logic [CNT_W-1:0]   rem,
                                                input logic [DIGIT_W-1:0] dig,
                                                input logic [CNT_W-1:0]   cnt);
    logic [CNT_W:0] r;
    r = {1'b0, rem};
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      r = {r[CNT_W-1:0], dig[i]};
      if (r >= {1'b0, cnt}) begin
        r = r - {1'b0, cnt};
      end
    end
    return r[CNT_W-1:0];
  endfunction

endpackage

FILE: rtl/gia_remdiv.sv
// gia_remdiv: pipelined remainder of an index magnitude by the axis count,
// DIGIT_W quotient bits per stage. Depends on gia_pkg.
module gia_remdiv import gia_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [INDEX_BITS-1:0] mag_i,
  input  gia_side_t             side_i,
  input  logic [CNT_W-1:0]      count_i,
  output logic                  valid_o,
  output logic [CNT_W-1:0]      rem_o,
  output gia_side_t             side_o
);

  localparam int NSTG  = (INDEX_BITS + DIGIT_W - 1) / DIGIT_W;
  localparam int PAD_W = NSTG * DIGIT_W;

  logic             vld_q  [NSTG];
  logic [PAD_W-1:0] mag_q  [NSTG];
  logic [CNT_W-1:0] rem_q  [NSTG];
  gia_side_t        side_q [NSTG];

  logic             vld_in  [NSTG];
  logic [PAD_W-1:0] mag_in  [NSTG];
  logic [CNT_W-1:0] rem_in  [NSTG];
  gia_side_t        side_in [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign vld_in[s]  = valid_i;
      assign mag_in[s]  = PAD_W'(mag_i);
      assign rem_in[s]  = '0;
      assign side_in[s] = side_i;
    end else begin : g_next
      assign vld_in[s]  = vld_q[s-1];
      assign mag_in[s]  = mag_q[s-1];
      assign rem_in[s]  = rem_q[s-1];
      assign side_in[s] = side_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mag_q[s]  <= mag_in[s] << DIGIT_W;
        rem_q[s]  <= rem_step(rem_in[s], mag_in[s][PAD_W-1 -: DIGIT_W], count_i);
        side_q[s] <= side_in[s];
      end
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign rem_o   = rem_q[NSTG-1];
  assign side_o  = side_q[NSTG-1];

endmodule

FILE: rtl/gia_addr.sv
// gia_addr: final index fix-up and offset arithmetic, four register stages:
// index select, row*count, add index, scale by chunk length. Depends on gia_pkg.
module gia_addr import gia_pkg::*; #(
  parameter int MAX_CHUNK = MAX_CHUNK_DEF,
  localparam int CW       = $clog2(MAX_CHUNK + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [CNT_W-1:0] rem_i,
  input  gia_side_t        side_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [CW-1:0]    nel_i,
  output gia_tail_t        tail_o
);

  logic [CNT_W-1:0]    idx_d;
  logic                s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic [CNT_W-1:0]    s1_idx_q, s2_idx_q;
  logic [ROW_W-1:0]    s1_row_q;
  logic [2:0]          s1_flg_q, s2_flg_q, s3_flg_q, s4_flg_q;  // {bad, rend, spare}
  logic [PROD_W-1:0]   s2_prod_q;
  logic [SUM_W-1:0]    s3_sum_q;
  logic [SUM_W+CW-1:0] scaled;
  logic [OFF_W-1:0]    s4_off_q;

  always_comb begin
    if (side_i.wrap) begin
      idx_d = (side_i.neg && (rem_i != '0)) ? (count_i - rem_i) : rem_i;
    end else begin
      idx_d = side_i.idx;
    end
  end

  assign scaled = s3_sum_q * nel_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_idx_q  <= idx_d;
      s1_row_q  <= side_i.row;
      s1_flg_q  <= {side_i.bad, side_i.rend, 1'b0};
      s2_prod_q <= PROD_W'(s1_row_q) * PROD_W'(count_i);
      s2_idx_q  <= s1_idx_q;
      s2_flg_q  <= s1_flg_q;
      s3_sum_q  <= SUM_W'(s2_prod_q) + SUM_W'(s2_idx_q);
      s3_flg_q  <= s2_flg_q;
      s4_off_q  <= scaled[OFF_W-1:0];
      s4_flg_q  <= s3_flg_q;
    end
  end

  assign tail_o.valid  = s4_vld_q;
  assign tail_o.bad    = s4_flg_q[2];
  assign tail_o.rend   = s4_flg_q[1] | (s4_flg_q[0] & 1'b0);
  assign tail_o.offset = s4_off_q;

endmodule

FILE: rtl/gia_emit.sv
// gia_emit: result sequencer; turns one address item into chunk-length
// consecutive offsets or a single error result. Depends on gia_pkg.
module gia_emit import gia_pkg::*; #(
  parameter int MAX_CHUNK = MAX_CHUNK_DEF,
  localparam int CW       = $clog2(MAX_CHUNK + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gia_tail_t        tail_i,
  input  logic [CW-1:0]    nel_i,
  output logic             stall_o,
  output logic             result_valid_o,
  output logic [OFF_W-1:0] source_offset_o,
  output logic             index_error_o,
  output logic             last_of_item_o,
  output logic             row_done_o
);

  logic             em_valid_q;
  logic [OFF_W-1:0] off_q;
  logic [CW-1:0]    rem_q;
  logic             err_q;
  logic             rend_q;
  logic             em_last;
  logic             load;

  assign em_last = em_valid_q && (rem_q == CW'(1));
  assign load    = tail_i.valid && (!em_valid_q || em_last);
  assign stall_o = tail_i.valid && em_valid_q && !em_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q <= 1'b0;
    end else if (load) begin
      em_valid_q <= 1'b1;
    end else if (em_last) begin
      em_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      off_q  <= tail_i.bad ? '0 : tail_i.offset;
      rem_q  <= tail_i.bad ? CW'(1) : nel_i;
      err_q  <= tail_i.bad;
      rend_q <= tail_i.rend;
    end else if (em_valid_q) begin
      off_q <= off_q + OFF_W'(1);
      rem_q <= rem_q - CW'(1);
    end
  end

  assign result_valid_o  = em_valid_q;
  assign source_offset_o = off_q;
  assign index_error_o   = em_valid_q && err_q;
  assign last_of_item_o  = em_last;
  assign row_done_o      = em_last && rend_q;

endmodule

FILE: rtl/gather_index_address_gen_core.sv
// gather_index_address_gen_core: top level of the gather index address generator.
// Holds configuration, input register and index classification; instantiates
// gia_remdiv, gia_addr and gia_emit. Depends on gia_pkg.
//
// Each transfer on start/busy carries one index; it yields chunk_len consecutive
// element offsets, or one error result (raise mode out of range, or a count of
// zero). The first result of an item shows on the result ports after the input
// register, which loads at the accepting edge, then one remainder stage per four
// index bits, four address stages and the output sequencer. An item enters every
// cycle while busy is low; the output sequencer delivers one result per cycle,
// and busy is high while the sequencer is still delivering a multi-result item
// and the next one waits behind it. Results are shown for one cycle with
// result_valid_o and cannot be held off. Configuration must be written only
// while no item is in flight.
module gather_index_address_gen_core import gia_pkg::*; #(
  parameter int MAX_CHUNK  = MAX_CHUNK_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [IDX_IN_W-1:0]  index_value_i,
  input  logic [ROW_W-1:0]     outer_row_i,
  input  logic                 row_end_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 result_valid_o,
  output logic [OFF_W-1:0]     source_offset_o,
  output logic                 index_error_o,
  output logic                 last_of_item_o,
  output logic                 row_done_o
);

  localparam int CW = $clog2(MAX_CHUNK + 1);
  localparam int MW = (INDEX_BITS > CNT_W) ? INDEX_BITS : CNT_W;

  logic [MODE_W-1:0]     mode_q;
  logic [CNT_W-1:0]      count_q;
  logic [CHUNK_W-1:0]    chunk_q;
  logic [CW-1:0]         nel;

  logic                  stall;
  logic                  in_valid_q;
  logic [INDEX_BITS-1:0] index_q;
  logic [ROW_W-1:0]      row_q;
  logic                  rend_q;

  logic                  neg;
  logic [INDEX_BITS-1:0] mag;
  logic [MW-1:0]         mag_x;
  logic [MW-1:0]         cnt_x;
  logic                  raise_bad;
  gia_side_t             side;

  logic                  div_valid;
  logic [CNT_W-1:0]      div_rem;
  gia_side_t             div_side;
  gia_tail_t             tail;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RAISE;
      count_q <= CNT_W'(1);
      chunk_q <= CHUNK_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:  mode_q  <= cfg_wdata_i[MODE_W-1:0];
        REG_COUNT: count_q <= cfg_wdata_i[CNT_W-1:0];
        REG_CHUNK: chunk_q <= cfg_wdata_i[CHUNK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (chunk_q == '0) begin
      nel = CW'(1);
    end else if (chunk_q > CHUNK_W'(MAX_CHUNK)) begin
      nel = CW'(MAX_CHUNK);
    end else begin
      nel = chunk_q[CW-1:0];
    end
  end

  assign busy = stall;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!stall) begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      index_q <= index_value_i[INDEX_BITS-1:0];
      row_q   <= outer_row_i;
      rend_q  <= row_end_i;
    end
  end

  // classification: raise and clip resolved here, wrap after the remainder
  assign neg   = index_q[INDEX_BITS-1];
  assign mag   = neg ? (~index_q + INDEX_BITS'(1)) : index_q;
  assign mag_x = MW'(mag);
  assign cnt_x = MW'(count_q);
  assign raise_bad = neg ? (mag_x > cnt_x) : (mag_x >= cnt_x);

  always_comb begin
    side.row  = row_q;
    side.rend = rend_q;
    side.neg  = neg;
    side.wrap = 1'b0;
    side.bad  = (count_q == '0);
    side.idx  = '0;
    unique case (mode_q)
      MODE_RAISE: begin
        side.bad = (count_q == '0) || raise_bad;
        side.idx = neg ? (count_q - mag_x[CNT_W-1:0]) : mag_x[CNT_W-1:0];
      end
      MODE_WRAP: begin
        side.wrap = 1'b1;
      end
      default: begin
        if (neg) begin
          side.idx = '0;
        end else if (mag_x >= cnt_x) begin
          side.idx = count_q - CNT_W'(1);
        end else begin
          side.idx = mag_x[CNT_W-1:0];
        end
      end
    endcase
  end

  gia_remdiv #(
    .INDEX_BITS (INDEX_BITS)
  ) u_remdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (!stall),
    .valid_i (in_valid_q),
    .mag_i   (mag),
    .side_i  (side),
    .count_i (count_q),
    .valid_o (div_valid),
    .rem_o   (div_rem),
    .side_o  (div_side)
  );

  gia_addr #(
    .MAX_CHUNK (MAX_CHUNK)
  ) u_addr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (!stall),
    .valid_i (div_valid),
    .rem_i   (div_rem),
    .side_i  (div_side),
    .count_i (count_q),
    .nel_i   (nel),
    .tail_o  (tail)
  );

  gia_emit #(
    .MAX_CHUNK (MAX_CHUNK)
  ) u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tail_i          (tail),
    .nel_i           (nel),
    .stall_o         (stall),
    .result_valid_o  (result_valid_o),
    .source_offset_o (source_offset_o),
    .index_error_o   (index_error_o),
    .last_of_item_o  (last_of_item_o),
    .row_done_o      (row_done_o)
  );

endmodule

FILE: rtl/gia_checker.sv
// gia_checker: port-level assertions for gather_index_address_gen_core, with
// the bind that attaches it. Depends on gia_pkg.
module gia_checker import gia_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 busy,
  input logic                 result_valid_o,
  input logic [OFF_W-1:0]     source_offset_o,
  input logic                 index_error_o,
  input logic                 last_of_item_o,
  input logic                 row_done_o
);

  a_flags_need_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> !index_error_o && !last_of_item_o && !row_done_o)
    else $error("result flags without strobe");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && index_error_o |-> last_of_item_o && source_offset_o == '0)
    else $error("error result not a lone zero-offset transfer");

  a_chunk_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_of_item_o |=>
      result_valid_o && !index_error_o &&
      source_offset_o == $past(source_offset_o) + OFF_W'(1))
    else $error("chunk offsets not consecutive");

  a_row_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_done_o |-> last_of_item_o)
    else $error("row_done off the final result");

  a_busy_only_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> result_valid_o && !last_of_item_o)
    else $error("busy while not delivering a multi-result item");

endmodule

bind gather_index_address_gen_core gia_checker u_gia_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .busy            (busy),
  .result_valid_o  (result_valid_o),
  .source_offset_o (source_offset_o),
  .index_error_o   (index_error_o),
  .last_of_item_o  (last_of_item_o),
  .row_done_o      (row_done_o)
);
